// ===== hw/rtl/smts_pkg.sv =====
// Shared types and codes for the sorted multi-timer service unit.
// Used by the front end, the command queue, the back end and the top level.
package smts_pkg;

    localparam int TIME_W      = 48;
    localparam int MaxResults  = 16;

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_INVALID_ID   = 3'd1;
    localparam logic [2:0] ST_NO_FREE_ID   = 3'd2;
    localparam logic [2:0] ST_DELAY_SHORT  = 3'd3;
    localparam logic [2:0] ST_NOT_RUNNING  = 3'd4;
    localparam logic [2:0] ST_DELETED_RUN  = 3'd5;
    localparam logic [2:0] ST_EXPIRED      = 3'd6;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  index;
        logic        index_ok;
        logic [31:0] delay;
    } cmd_t;

endpackage

// ===== hw/rtl/sorted_multi_timer_service_unit.sv =====
// Top level of the sorted multi-timer service unit.
// Depends on smts_pkg, smts_front, smts_queue and smts_back.
//
// A command transaction is taken when start is high and busy is low; a
// two-entry queue buffers commands, so busy rises only when both entries are
// held. Every result appears for exactly one cycle with done high and must be
// captured then. Create, stop, delete and unknown commands are popped from the
// queue into the back end's command register and executed in its EXEC state,
// which registers their result. A start searches the insertion point one
// deadline RAM read at a time, passing the queued timers whose deadlines are
// not later than its own. A tick gives one result for each expired timer,
// bounded by the deadline RAM read for each queue head, and the final result
// has last set.
module sorted_multi_timer_service_unit #(
    parameter int NUM_TIMERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [7:0]  timer_index,
    input  logic [31:0] delay_ms,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic [3:0]  result_timer,
    output logic        fired,
    output logic        last
);

    localparam logic [1:0] REG_TICK_LENGTH = 2'd0;
    localparam logic [1:0] REG_MIN_DELAY   = 2'd1;

    logic [15:0]    tick_length_reg, tick_length_next;
    logic [15:0]    min_delay_reg, min_delay_next;
    logic           q_full;
    logic           q_empty;
    logic           push;
    logic           pop;
    smts_pkg::cmd_t push_data;
    smts_pkg::cmd_t q_head;

    always_comb
    begin
        tick_length_next = tick_length_reg;
        min_delay_next   = min_delay_reg;
        if (cfg_write && (cfg_index == REG_TICK_LENGTH))
        begin
            tick_length_next = cfg_data;
        end
        if (cfg_write && (cfg_index == REG_MIN_DELAY))
        begin
            min_delay_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_length_reg <= 16'd10;
            min_delay_reg   <= 16'd10;
        end
        else
        begin
            tick_length_reg <= tick_length_next;
            min_delay_reg   <= min_delay_next;
        end
    end

    smts_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .start       (start),
        .cmd         (cmd),
        .timer_index (timer_index),
        .delay_ms    (delay_ms),
        .q_full      (q_full),
        .busy        (busy),
        .push        (push),
        .push_data   (push_data)
    );

    smts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    smts_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (pop),
        .tick_length  (tick_length_reg),
        .min_delay    (min_delay_reg),
        .done         (done),
        .status       (status),
        .result_timer (result_timer),
        .fired        (fired),
        .last         (last)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        done && fired |-> status == smts_pkg::ST_EXPIRED)
        else $error("fired result without expired status");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> fired)
        else $error("non-final result that is not an expiry");
`endif

endmodule

// ===== hw/rtl/smts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module smts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/smts_front.sv =====
// Front end: accepts command transactions and classifies the timer index.
// Depends on smts_pkg.
module smts_front #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                 start,
    input  logic [2:0]           cmd,
    input  logic [7:0]           timer_index,
    input  logic [31:0]          delay_ms,
    input  logic                 q_full,
    output logic                 busy,
    output logic                 push,
    output smts_pkg::cmd_t       push_data
);

    assign busy = q_full;
    assign push = start && !q_full;

    always_comb
    begin
        push_data.op       = cmd;
        push_data.index    = timer_index;
        push_data.index_ok = ({24'd0, timer_index} < 32'(NUM_TIMERS));
        push_data.delay    = delay_ms;
    end

endmodule

// ===== hw/rtl/smts_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on smts_pkg.
module smts_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  smts_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output smts_pkg::cmd_t head
);

    smts_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/smts_back.sv =====
// Back end: executes queued commands against the timer pool and sorted queue.
// Depends on smts_pkg and smts_ram.
module smts_back #(
    parameter int NUM_TIMERS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  smts_pkg::cmd_t q_head,
    output logic           q_pop,
    input  logic [15:0]    tick_length,
    input  logic [15:0]    min_delay,
    output logic           done,
    output logic [2:0]     status,
    output logic [3:0]     result_timer,
    output logic           fired,
    output logic           last
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int TW = smts_pkg::TIME_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_INS_RD  = 3'd2;
    localparam logic [2:0] S_INS_CMP = 3'd3;
    localparam logic [2:0] S_TK_RD   = 3'd4;
    localparam logic [2:0] S_TK_CMP  = 3'd5;

    logic [2:0]           state_reg, state_next;
    smts_pkg::cmd_t       cmd_reg, cmd_next;
    logic [TW-1:0]        now_reg, now_next;
    logic [NUM_TIMERS-1:0] alloc_reg, alloc_next;
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic [IW-1:0]        order_reg [NUM_TIMERS];
    logic [IW-1:0]        order_next [NUM_TIMERS];
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [TW-1:0]        new_dl_reg, new_dl_next;
    logic [4:0]           nfire_reg, nfire_next;
    logic                 pend_reg, pend_next;
    logic [IW-1:0]        pend_id_reg, pend_id_next;
    logic                 done_reg, done_next;
    logic [2:0]           status_reg, status_next;
    logic [3:0]           timer_reg, timer_next;
    logic                 fired_reg, fired_next;
    logic                 last_reg, last_next;

    logic [IW-1:0] id;
    logic          id_valid;
    logic [IW-1:0] free_id;
    logic          free_any;
    logic [CW-1:0] hit_at;
    logic          do_rm;
    logic [CW-1:0] rm_at;
    logic          do_ins;
    logic [TW-1:0] start_dl;
    logic          ram_we;
    logic [IW-1:0] ram_raddr;
    logic [TW-1:0] ram_rdata;
    logic [IW-1:0] head_id;

    smts_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_TIMERS)
    ) u_deadline_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (id),
        .wdata (start_dl),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign id       = cmd_reg.index[IW-1:0];
    assign id_valid = cmd_reg.index_ok && alloc_reg[id];
    assign start_dl = now_reg + {16'd0, cmd_reg.delay};
    assign head_id  = order_reg[0];

    always_comb
    begin
        free_id  = '0;
        free_any = 1'b0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!alloc_reg[i])
            begin
                free_id  = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        hit_at = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if ((CW'(i) < count_reg) && (order_reg[i] == id))
            begin
                hit_at = CW'(i);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_TIMERS; j++)
        begin
            order_next[j] = order_reg[j];
            if (do_rm && (CW'(j) >= rm_at))
            begin
                order_next[j] = order_reg[(j + 1 < NUM_TIMERS) ? j + 1 : j];
            end
            if (do_ins)
            begin
                if (CW'(j) > pos_reg)
                begin
                    order_next[j] = order_reg[(j > 0) ? j - 1 : j];
                end
                else if (CW'(j) == pos_reg)
                begin
                    order_next[j] = id;
                end
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        now_next     = now_reg;
        alloc_next   = alloc_reg;
        armed_next   = armed_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        new_dl_next  = new_dl_reg;
        nfire_next   = nfire_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        done_next    = 1'b0;
        status_next  = smts_pkg::ST_OK;
        timer_next   = 4'd0;
        fired_next   = 1'b0;
        last_next    = 1'b1;
        q_pop        = 1'b0;
        do_rm        = 1'b0;
        rm_at        = hit_at;
        do_ins       = 1'b0;
        ram_we       = 1'b0;
        ram_raddr    = order_reg[pos_reg[IW-1:0]];

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                unique case (cmd_reg.op)
                    smts_pkg::OP_CREATE:
                    begin
                        if (free_any)
                        begin
                            alloc_next[free_id] = 1'b1;
                            armed_next[free_id] = 1'b0;
                            timer_next          = 4'(free_id);
                        end
                        else
                        begin
                            status_next = smts_pkg::ST_NO_FREE_ID;
                        end
                    end
                    smts_pkg::OP_START:
                    begin
                        if (!id_valid)
                        begin
                            status_next = smts_pkg::ST_INVALID_ID;
                        end
                        else if (cmd_reg.delay < {16'd0, min_delay})
                        begin
                            status_next = smts_pkg::ST_DELAY_SHORT;
                        end
                        else
                        begin
                            done_next   = 1'b0;
                            ram_we      = 1'b1;
                            new_dl_next = start_dl;
                            pos_next    = '0;
                            state_next  = S_INS_RD;
                            if (armed_reg[id])
                            begin
                                do_rm      = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                        end
                    end
                    smts_pkg::OP_STOP:
                    begin
                        if (!id_valid)
                        begin
                            status_next = smts_pkg::ST_INVALID_ID;
                        end
                        else if (!armed_reg[id])
                        begin
                            status_next = smts_pkg::ST_NOT_RUNNING;
                        end
                        else
                        begin
                            do_rm          = 1'b1;
                            count_next     = count_reg - CW'(1);
                            armed_next[id] = 1'b0;
                        end
                    end
                    smts_pkg::OP_DELETE:
                    begin
                        if (!id_valid)
                        begin
                            status_next = smts_pkg::ST_INVALID_ID;
                        end
                        else
                        begin
                            alloc_next[id] = 1'b0;
                            if (armed_reg[id])
                            begin
                                do_rm          = 1'b1;
                                count_next     = count_reg - CW'(1);
                                armed_next[id] = 1'b0;
                                status_next    = smts_pkg::ST_DELETED_RUN;
                            end
                        end
                    end
                    smts_pkg::OP_TICK:
                    begin
                        done_next  = 1'b0;
                        now_next   = now_reg + {32'd0, tick_length};
                        nfire_next = 5'd0;
                        pend_next  = 1'b0;
                        state_next = S_TK_RD;
                    end
                    default:
                    begin
                        status_next = smts_pkg::ST_INVALID_ID;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (pos_reg == count_reg)
                begin
                    do_ins         = 1'b1;
                    count_next     = count_reg + CW'(1);
                    armed_next[id] = 1'b1;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (new_dl_reg < ram_rdata)
                begin
                    do_ins         = 1'b1;
                    count_next     = count_reg + CW'(1);
                    armed_next[id] = 1'b1;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    pos_next   = pos_reg + CW'(1);
                    state_next = S_INS_RD;
                end
            end
            S_TK_RD:
            begin
                ram_raddr = head_id;
                if ((nfire_reg == 5'(smts_pkg::MaxResults)) || (count_reg == '0))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (pend_reg)
                    begin
                        status_next = smts_pkg::ST_EXPIRED;
                        timer_next  = 4'(pend_id_reg);
                        fired_next  = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_TK_CMP;
                end
            end
            S_TK_CMP:
            begin
                if (ram_rdata < now_reg)
                begin
                    do_rm               = 1'b1;
                    rm_at               = '0;
                    count_next          = count_reg - CW'(1);
                    armed_next[head_id] = 1'b0;
                    nfire_next          = nfire_reg + 5'd1;
                    pend_next           = 1'b1;
                    pend_id_next        = head_id;
                    state_next          = S_TK_RD;
                    if (pend_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = smts_pkg::ST_EXPIRED;
                        timer_next  = 4'(pend_id_reg);
                        fired_next  = 1'b1;
                        last_next   = 1'b0;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (pend_reg)
                    begin
                        status_next = smts_pkg::ST_EXPIRED;
                        timer_next  = 4'(pend_id_reg);
                        fired_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        new_dl_reg  <= new_dl_next;
        pend_id_reg <= pend_id_next;
        status_reg  <= status_next;
        timer_reg   <= timer_next;
        fired_reg   <= fired_next;
        last_reg    <= last_next;
        for (int j = 0; j < NUM_TIMERS; j++)
        begin
            order_reg[j] <= order_next[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            now_reg   <= '0;
            alloc_reg <= '0;
            armed_reg <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            nfire_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            alloc_reg <= alloc_next;
            armed_reg <= armed_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            nfire_reg <= nfire_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign result_timer = timer_reg;
    assign fired        = fired_reg;
    assign last         = last_reg;

endmodule
